// ===== src/vmbm_pkg.sv =====
// Package: types, constants and mask helpers for the video memory bank mapper.
`timescale 1ns / 1ps
`default_nettype none
package vmbm_pkg;
	localparam int NumBanks = 9;

	localparam logic [7:0] EnableBit = 8'h80;
	localparam logic [5:0] LcdcE = 6'h20;
	localparam logic [5:0] LcdcF = 6'h24;
	localparam logic [5:0] LcdcH = 6'h26;
	localparam logic [5:0] LcdcI = 6'h28;

	localparam logic OpWrite  = 1'b0;
	localparam logic OpLookup = 1'b1;

	localparam logic [3:0] RegLcdc  = 4'd0;
	localparam logic [3:0] RegAbg   = 4'd1;
	localparam logic [3:0] RegAobj  = 4'd2;
	localparam logic [3:0] RegBbg   = 4'd3;
	localparam logic [3:0] RegBobj  = 4'd4;
	localparam logic [3:0] RegArm7  = 4'd5;
	localparam logic [3:0] RegAbgPl = 4'd6;
	localparam logic [3:0] RegBbgPl = 4'd7;
	localparam logic [3:0] RegAobPl = 4'd8;
	localparam logic [3:0] RegBobPl = 4'd9;
	localparam logic [3:0] RegTex   = 4'd10;
	localparam logic [3:0] RegTexPl = 4'd11;

	typedef logic [NumBanks-1:0] bmask_t;

	typedef struct packed {
		logic       operation;
		logic [3:0] bank;
		logic [7:0] control;
		logic [3:0] region;
		logic [5:0] slot;
	} in_item_t;

	typedef struct packed {
		logic       error;
		logic       mapped;
		logic       conflict;
		logic [3:0] bank_id;
		logic [2:0] page;
		bmask_t     overlap_mask;
		logic [1:0] arm7_status;
	} out_item_t;

	// Full mapping state.
	typedef struct packed {
		logic [NumBanks-1:0][7:0] ctl;
		logic [NumBanks-1:0]      en;
		logic [31:0][8:0]         abg;
		logic [15:0][8:0]         aobj;
		logic [3:0][8:0]          bbg;
		logic [8:0]               bobj;
		logic [1:0][8:0]          arm7;
		logic [1:0][8:0]          abgpl;
		logic [8:0]               aobjpl;
		logic [3:0][8:0]          tex;
		logic [5:0][8:0]          texpl;
		logic [1:0]               spal;
		logic [1:0]               arm7b;
	} map_state_t;

	function automatic logic [2:0] mode_mask(input logic [3:0] b);
		case (b)
			4'd0, 4'd1, 4'd7, 4'd8: mode_mask = 3'd3;
			default:               mode_mask = 3'd7;
		endcase
	endfunction

	function automatic logic [2:0] page_mask(input logic [3:0] b);
		case (b)
			4'd0, 4'd1, 4'd2, 4'd3: page_mask = 3'd7;
			4'd4:                  page_mask = 3'd3;
			4'd7:                  page_mask = 3'd1;
			default:               page_mask = 3'd0;
		endcase
	endfunction
endpackage
`default_nettype wire

// ===== src/vmbm_update.sv =====
// Next-state logic for a bank control write.
`timescale 1ns / 1ps
`default_nettype none
module vmbm_update
	import vmbm_pkg::*;
(
	input  var map_state_t cur,
	input  var logic [3:0] bank,
	input  var logic [7:0] control,
	output map_state_t     nxt,
	output logic           error
);
	// Set or clear one bank's bits for a control byte; returns false on bad mode.
	function automatic logic apply(inout map_state_t s, input logic [3:0] b,
			input logic [7:0] c, input logic set);
		logic [2:0] mode;
		logic [1:0] ofs;
		logic [2:0] fg;
		logic [8:0] bit_m;
		logic       ok;
		mode  = c[2:0] & mode_mask(b);
		ofs   = c[4:3];
		fg    = {ofs[1], 1'b0, ofs[0]};
		bit_m = 9'(1) << b;
		ok    = 1'b1;
		if (mode != 3'd0) begin
			case (b)
				4'd0, 4'd1: begin
					if (mode == 3'd1) begin
						for (int i = 0; i < 32; i++)
							if (i[4:3] == ofs)
								s.abg[i] = set ? s.abg[i] | bit_m : s.abg[i] & ~bit_m;
					end else if (mode == 3'd2) begin
						for (int i = 0; i < 16; i++)
							if (i[3] == ofs[0])
								s.aobj[i] = set ? s.aobj[i] | bit_m : s.aobj[i] & ~bit_m;
					end else begin
						s.tex[ofs] = set ? s.tex[ofs] | bit_m : s.tex[ofs] & ~bit_m;
					end
				end
				4'd2, 4'd3: begin
					if (mode == 3'd1) begin
						for (int i = 0; i < 32; i++)
							if (i[4:3] == ofs)
								s.abg[i] = set ? s.abg[i] | bit_m : s.abg[i] & ~bit_m;
					end else if (mode == 3'd2) begin
						s.arm7[ofs[0]] = set ? s.arm7[ofs[0]] | bit_m
							: s.arm7[ofs[0]] & ~bit_m;
						s.arm7b[b[0]] = set;
					end else if (mode == 3'd3) begin
						s.tex[ofs] = set ? s.tex[ofs] | bit_m : s.tex[ofs] & ~bit_m;
					end else if (mode == 3'd4) begin
						if (b == 4'd2) begin
							for (int i = 0; i < 4; i++)
								s.bbg[i] = set ? s.bbg[i] | bit_m : s.bbg[i] & ~bit_m;
						end else begin
							s.bobj = set ? s.bobj | bit_m : s.bobj & ~bit_m;
						end
					end else begin
						ok = 1'b0;
					end
				end
				4'd4: begin
					if (mode == 3'd1) begin
						for (int i = 0; i < 4; i++)
							s.abg[i] = set ? s.abg[i] | bit_m : s.abg[i] & ~bit_m;
					end else if (mode == 3'd2) begin
						for (int i = 0; i < 4; i++)
							s.aobj[i] = set ? s.aobj[i] | bit_m : s.aobj[i] & ~bit_m;
					end else if (mode == 3'd3) begin
						for (int i = 0; i < 4; i++)
							s.texpl[i] = set ? s.texpl[i] | bit_m : s.texpl[i] & ~bit_m;
					end else if (mode == 3'd4) begin
						for (int i = 0; i < 2; i++)
							s.abgpl[i] = set ? s.abgpl[i] | bit_m : s.abgpl[i] & ~bit_m;
					end else begin
						ok = 1'b0;
					end
				end
				4'd5, 4'd6: begin
					if (mode == 3'd1) begin
						s.abg[5'(fg)] = set ? s.abg[5'(fg)] | bit_m : s.abg[5'(fg)] & ~bit_m;
						s.abg[5'(fg | 3'd2)] = set ? s.abg[5'(fg | 3'd2)] | bit_m
							: s.abg[5'(fg | 3'd2)] & ~bit_m;
					end else if (mode == 3'd2) begin
						s.aobj[4'(fg)] = set ? s.aobj[4'(fg)] | bit_m
							: s.aobj[4'(fg)] & ~bit_m;
						s.aobj[4'(fg | 3'd2)] = set ? s.aobj[4'(fg | 3'd2)] | bit_m
							: s.aobj[4'(fg | 3'd2)] & ~bit_m;
					end else if (mode == 3'd3) begin
						s.texpl[fg] = set ? s.texpl[fg] | bit_m : s.texpl[fg] & ~bit_m;
					end else if (mode == 3'd4) begin
						s.abgpl[ofs[0]] = set ? s.abgpl[ofs[0]] | bit_m
							: s.abgpl[ofs[0]] & ~bit_m;
					end else if (mode == 3'd5) begin
						s.aobjpl = set ? s.aobjpl | bit_m : s.aobjpl & ~bit_m;
					end else begin
						ok = 1'b0;
					end
				end
				4'd7: begin
					if (mode == 3'd1) begin
						s.bbg[0] = set ? s.bbg[0] | bit_m : s.bbg[0] & ~bit_m;
						s.bbg[2] = set ? s.bbg[2] | bit_m : s.bbg[2] & ~bit_m;
					end else if (mode == 3'd2) begin
						s.spal[0] = set;
					end else begin
						ok = 1'b0;
					end
				end
				default: begin
					if (mode == 3'd1) begin
						s.bbg[1] = set ? s.bbg[1] | bit_m : s.bbg[1] & ~bit_m;
						s.bbg[3] = set ? s.bbg[3] | bit_m : s.bbg[3] & ~bit_m;
					end else if (mode == 3'd2) begin
						s.bobj = set ? s.bobj | bit_m : s.bobj & ~bit_m;
					end else begin
						s.spal[1] = set;
					end
				end
			endcase
		end
		return ok;
	endfunction

	always_comb begin
		map_state_t s;
		s     = cur;
		error = 1'b0;
		if (bank < 4'(NumBanks) && control != cur.ctl[bank]) begin
			if (cur.en[bank])
				void'(apply(s, bank, cur.ctl[bank], 1'b0));
			s.en[bank] = 1'b0;
			if ((control & EnableBit) != 8'd0) begin
				if (apply(s, bank, control, 1'b1))
					s.en[bank] = 1'b1;
				else
					error = 1'b1;
			end
			s.ctl[bank] = control;
		end
		nxt = s;
	end
endmodule
`default_nettype wire

// ===== src/vmbm_lookup.sv =====
// Slot lookup: select the bank mask, count owners and form the page.
`timescale 1ns / 1ps
`default_nettype none
module vmbm_lookup
	import vmbm_pkg::*;
(
	input  var map_state_t cur,
	input  var logic [3:0] region,
	input  var logic [5:0] slot,
	output out_item_t      res
);
	logic [3:0] lb;
	logic       lb_ok;

	// Bank behind an lcdc slot.
	always_comb begin
		lb_ok = 1'b1;
		lb    = 4'd0;
		if (slot < LcdcE)      lb = {1'b0, slot[5:3]};
		else if (slot < LcdcF) lb = 4'd4;
		else if (slot < LcdcH) lb = 4'd5 + 4'(slot - LcdcF);
		else if (slot < LcdcI) lb = 4'd7;
		else if (slot == LcdcI) lb = 4'd8;
		else lb_ok = 1'b0;
	end

	always_comb begin
		bmask_t     m;
		logic       whole;
		logic [3:0] cnt;
		logic [3:0] id;
		m     = '0;
		whole = 1'b0;
		case (region)
			RegLcdc:
				if (lb_ok && cur.en[lb] && (cur.ctl[lb][2:0] & mode_mask(lb)) == 3'd0)
					m = bmask_t'(1) << lb;
			RegAbg:   if (slot < 6'd32) m = cur.abg[slot[4:0]];
			RegAobj:  if (slot < 6'd16) m = cur.aobj[slot[3:0]];
			RegBbg:   if (slot < 6'd8) m = cur.bbg[slot[2:1]];
			RegBobj:  if (slot < 6'd8) m = cur.bobj;
			RegArm7: begin
				if (slot < 6'd2) m = cur.arm7[slot[0]];
				whole = 1'b1;
			end
			RegAbgPl: if (slot < 6'd2) m = cur.abgpl[slot[0]];
			RegBbgPl: if (slot == 6'd0 && cur.spal[0]) m = bmask_t'(1) << 7;
			RegAobPl: if (slot == 6'd0) m = cur.aobjpl;
			RegBobPl: if (slot == 6'd0 && cur.spal[1]) m = bmask_t'(1) << 8;
			RegTex: begin
				if (slot < 6'd4) m = cur.tex[slot[1:0]];
				whole = 1'b1;
			end
			RegTexPl: if (slot < 6'd6) m = cur.texpl[slot[2:0]];
			default: m = '0;
		endcase
		cnt = 4'($countones(m));
		id  = 4'd0;
		for (int i = NumBanks - 1; i >= 0; i--)
			if (m[i]) id = 4'(i);
		res.error        = 1'b0;
		res.mapped       = (cnt == 4'd1);
		res.conflict     = (cnt >= 4'd2);
		res.bank_id      = (cnt == 4'd1) ? id : 4'd0;
		res.page         = (cnt == 4'd1 && !whole) ? (slot[2:0] & page_mask(id)) : 3'd0;
		res.overlap_mask = m;
		res.arm7_status  = cur.arm7b;
	end
endmodule
`default_nettype wire

// ===== src/video_memory_bank_mapper_unit.sv =====
// Top level of the video memory bank mapper.
// Input channel in_item (in_valid/in_stall) carries either a bank control
// write or a slot lookup; output channel out_item (out_valid/out_stall)
// returns exactly one result per input item, in order.
// A control write updates the bank masks and reports error and the ARM7
// status after the write; a lookup reports owning bank, page, overlap mask.
// An accepted item passes through two registers: the input register, then
// the result register.
// Throughput: one item per cycle while out_stall is low; the mask update
// and lookup logic between the input and result registers is combinational.
// Asynchronous reset clears all mappings and control bytes and empties both
// registers. When the receiver stalls, the result holds, the input register
// fills and in_stall rises once both hold an item.
`timescale 1ns / 1ps
`default_nettype none
module video_memory_bank_mapper_unit
	import vmbm_pkg::*;
(
	input  var logic      clk,
	input  var logic      arst_n,
	input  var logic      in_valid,
	output logic          in_stall,
	input  var in_item_t  in_item,
	output logic          out_valid,
	input  var logic      out_stall,
	output out_item_t     out_item
);
	in_item_t   item_s1;
	logic       vld_s1;
	map_state_t st_q;
	map_state_t st_nxt;
	logic       wr_err;
	out_item_t  look_res;
	out_item_t  res;
	logic       adv;

	assign adv      = vld_s1 && (!out_valid || !out_stall);
	assign in_stall = vld_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) item_s1 <= in_item;
	end

	vmbm_update u_update (
		.cur(st_q), .bank(item_s1.bank), .control(item_s1.control),
		.nxt(st_nxt), .error(wr_err)
	);

	vmbm_lookup u_lookup (
		.cur(st_q), .region(item_s1.region), .slot(item_s1.slot), .res(look_res)
	);

	always_comb begin
		if (item_s1.operation == OpLookup) begin
			res = look_res;
		end else begin
			res             = '0;
			res.error       = wr_err;
			res.arm7_status = st_nxt.arm7b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= '0;
			out_valid <= 1'b0;
		end else begin
			if (adv && item_s1.operation == OpWrite) st_q <= st_nxt;
			if (adv) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) out_item <= res;
	end
endmodule
`default_nettype wire

// ===== src/vmbm_checker.sv =====
// Port-level checker for the video memory bank mapper, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module vmbm_checker
	import vmbm_pkg::*;
(
	input var logic      clk,
	input var logic      arst_n,
	input var logic      in_stall,
	input var logic      out_valid,
	input var logic      out_stall,
	input var out_item_t out_item
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result changed under stall");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_item.mapped && out_item.conflict))
		else $error("mapped and conflict both set");

	a_nostall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.mapped |-> $countones(out_item.overlap_mask) == 1)
		else $error("mapped with wrong overlap mask");
endmodule

bind video_memory_bank_mapper_unit vmbm_checker u_vmbm_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);
`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for the video memory bank mapper: directed table, then random writes and lookups.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import vmbm_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_item;

	video_memory_bank_mapper_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);

	// Predicted mapping state
	logic [7:0] p_ctl [NumBanks];
	logic       p_en [NumBanks];
	bmask_t     p_abg [32];
	bmask_t     p_aobj [16];
	bmask_t     p_bbg [4];
	bmask_t     p_bobj;
	bmask_t     p_arm7 [2];
	bmask_t     p_abgpl [2];
	bmask_t     p_aobjpl;
	bmask_t     p_tex [4];
	bmask_t     p_texpl [6];
	logic [1:0] p_small;
	logic [1:0] p_arm7b;

	out_item_t expected_results [$];
	int        errors;
	int        cycles;
	bit        long_hold;

	typedef struct {
		in_item_t  item;
		bit        typed;
		out_item_t res;
	} row_t;

	function automatic out_item_t mk_res(logic err, logic mp, logic cf, logic [3:0] id,
			logic [2:0] pg, bmask_t m, logic [1:0] a7);
		out_item_t r;
		r.error = err; r.mapped = mp; r.conflict = cf; r.bank_id = id;
		r.page = pg; r.overlap_mask = m; r.arm7_status = a7;
		return r;
	endfunction

	function automatic in_item_t wr(int b, int c);
		in_item_t it;
		it = '0;
		it.operation = OpWrite; it.bank = b[3:0]; it.control = c[7:0];
		return it;
	endfunction

	function automatic in_item_t rd(logic [3:0] r, int s);
		in_item_t it;
		it = '0;
		it.operation = OpLookup; it.region = r; it.slot = s[5:0];
		return it;
	endfunction

	function automatic logic [2:0] bank_modes(int b);
		return (b == 0 || b == 1 || b == 7 || b == 8) ? 3'd3 : 3'd7;
	endfunction

	function automatic logic [2:0] bank_pages(int b);
		case (b)
			0, 1, 2, 3: return 3'd7;
			4:          return 3'd3;
			7:          return 3'd1;
			default:    return 3'd0;
		endcase
	endfunction

	function automatic void upd(ref bmask_t m, input bmask_t bit_b, input bit set);
		m = set ? (m | bit_b) : (m & ~bit_b);
	endfunction

	// Set or clear bank b's bits for control byte c; returns 0 on an invalid mode.
	function automatic bit map_bank(int b, logic [7:0] c, bit set);
		int mode, ofs, fg;
		bmask_t bit_b;
		mode  = c[2:0] & bank_modes(b);
		ofs   = c[4:3];
		fg    = (ofs & 1) | ((ofs & 2) << 1);
		bit_b = bmask_t'(1) << b;
		if (mode == 0)
			return 1;
		case (b)
			0, 1: begin
				if (mode == 1) for (int i = 0; i < 8; i++) upd(p_abg[ofs*8+i], bit_b, set);
				else if (mode == 2) for (int i = 0; i < 8; i++)
					upd(p_aobj[(ofs&1)*8+i], bit_b, set);
				else upd(p_tex[ofs], bit_b, set);
			end
			2, 3: begin
				if (mode == 1) for (int i = 0; i < 8; i++) upd(p_abg[ofs*8+i], bit_b, set);
				else if (mode == 2) begin
					upd(p_arm7[ofs&1], bit_b, set);
					p_arm7b[b-2] = set;
				end else if (mode == 3) upd(p_tex[ofs], bit_b, set);
				else if (mode == 4) begin
					if (b == 2) for (int i = 0; i < 4; i++) upd(p_bbg[i], bit_b, set);
					else upd(p_bobj, bit_b, set);
				end else return 0;
			end
			4: begin
				if (mode == 1) for (int i = 0; i < 4; i++) upd(p_abg[i], bit_b, set);
				else if (mode == 2) for (int i = 0; i < 4; i++) upd(p_aobj[i], bit_b, set);
				else if (mode == 3) for (int i = 0; i < 4; i++) upd(p_texpl[i], bit_b, set);
				else if (mode == 4) for (int i = 0; i < 2; i++) upd(p_abgpl[i], bit_b, set);
				else return 0;
			end
			5, 6: begin
				if (mode == 1) begin
					upd(p_abg[fg], bit_b, set); upd(p_abg[fg|2], bit_b, set);
				end else if (mode == 2) begin
					upd(p_aobj[fg], bit_b, set); upd(p_aobj[fg|2], bit_b, set);
				end else if (mode == 3) upd(p_texpl[fg], bit_b, set);
				else if (mode == 4) upd(p_abgpl[ofs&1], bit_b, set);
				else if (mode == 5) upd(p_aobjpl, bit_b, set);
				else return 0;
			end
			7: begin
				if (mode == 1) begin
					upd(p_bbg[0], bit_b, set); upd(p_bbg[2], bit_b, set);
				end else if (mode == 2) p_small[0] = set;
				else return 0;
			end
			default: begin
				if (mode == 1) begin
					upd(p_bbg[1], bit_b, set); upd(p_bbg[3], bit_b, set);
				end else if (mode == 2) upd(p_bobj, bit_b, set);
				else p_small[1] = set;
			end
		endcase
		return 1;
	endfunction

	function automatic bmask_t lcdc_owner(int s);
		int b;
		if (s < LcdcE) b = s >> 3;
		else if (s < LcdcF) b = 4;
		else if (s < LcdcH) b = 5 + (s - LcdcF);
		else if (s < LcdcI) b = 7;
		else if (s == LcdcI) b = 8;
		else return '0;
		if (p_en[b] && (p_ctl[b] & bank_modes(b)) == 0)
			return bmask_t'(1) << b;
		return '0;
	endfunction

	function automatic out_item_t map_item(in_item_t it);
		out_item_t r;
		bmask_t m;
		bit whole;
		int s, cnt, id;
		r = '0; m = '0; whole = 0; s = it.slot; cnt = 0; id = 0;
		if (it.operation == OpWrite) begin
			int b;
			b = it.bank;
			if (b < NumBanks && it.control != p_ctl[b]) begin
				if (p_en[b])
					void'(map_bank(b, p_ctl[b], 0));
				p_en[b] = 0;
				if (it.control[7]) begin
					if (map_bank(b, it.control, 1)) p_en[b] = 1;
					else r.error = 1;
				end
				p_ctl[b] = it.control;
			end
		end else begin
			case (it.region)
				RegLcdc:  m = lcdc_owner(s);
				RegAbg:   if (s < 32) m = p_abg[s];
				RegAobj:  if (s < 16) m = p_aobj[s];
				RegBbg:   if (s < 8) m = p_bbg[s >> 1];
				RegBobj:  if (s < 8) m = p_bobj;
				RegArm7:  begin if (s < 2) m = p_arm7[s]; whole = 1; end
				RegAbgPl: if (s < 2) m = p_abgpl[s];
				RegBbgPl: if (s == 0 && p_small[0]) m = 9'h080;
				RegAobPl: if (s == 0) m = p_aobjpl;
				RegBobPl: if (s == 0 && p_small[1]) m = 9'h100;
				RegTex:   begin if (s < 4) m = p_tex[s]; whole = 1; end
				RegTexPl: if (s < 6) m = p_texpl[s];
				default: ;
			endcase
			for (int i = NumBanks - 1; i >= 0; i--)
				if (m[i]) begin cnt++; id = i; end
			if (cnt == 1) begin
				r.mapped = 1;
				r.bank_id = id[3:0];
				r.page = whole ? 3'd0 : (s[2:0] & bank_pages(id));
			end
			r.conflict = cnt >= 2;
			r.overlap_mask = m;
		end
		r.arm7_status = p_arm7b;
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, out_item);
				errors++;
			end else begin
				out_item_t e;
				e = expected_results.pop_front();
				if (e.error !== out_item.error)
					$display("%0t: error exp %h got %h", $time, e.error, out_item.error);
				if (e.mapped !== out_item.mapped)
					$display("%0t: mapped exp %h got %h", $time, e.mapped, out_item.mapped);
				if (e.conflict !== out_item.conflict)
					$display("%0t: conflict exp %h got %h", $time, e.conflict,
						out_item.conflict);
				if (e.bank_id !== out_item.bank_id)
					$display("%0t: bank_id exp %h got %h", $time, e.bank_id, out_item.bank_id);
				if (e.page !== out_item.page)
					$display("%0t: page exp %h got %h", $time, e.page, out_item.page);
				if (e.overlap_mask !== out_item.overlap_mask)
					$display("%0t: overlap_mask exp %h got %h", $time, e.overlap_mask,
						out_item.overlap_mask);
				if (e.arm7_status !== out_item.arm7_status)
					$display("%0t: arm7_status exp %h got %h", $time, e.arm7_status,
						out_item.arm7_status);
				if (e !== out_item)
					errors++;
			end
		end
	end

	// Receiver: random hold-offs, one long stretch on request
	initial begin
		int wait_n;
		out_stall = 1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_stall <= 1;
				repeat (60) @(posedge clk);
				long_hold = 0;
				out_stall <= 0;
			end else if (out_stall) begin
				out_stall <= 0;
			end else if (out_valid) begin
				wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
				if (wait_n > 0) begin
					out_stall <= 1;
					repeat (wait_n - 1) @(posedge clk);
				end
			end
		end
	end

	// Offer an item; valid stays high straight into the next item when there is no gap
	task automatic send(in_item_t it, bit typed, out_item_t res, int gap);
		out_item_t pred;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		in_item  <= it;
		do @(posedge clk); while (in_stall);
		pred = map_item(it);
		if (typed && pred !== res) begin
			$display("%0t: table row mismatch exp %h got %h", $time, res, pred);
			errors++;
		end
		expected_results.push_back(typed ? res : pred);
	endtask

	function automatic in_item_t rand_item();
		in_item_t it;
		it = '0;
		if ($urandom_range(0, 9) < 4) begin
			it.operation = OpWrite;
			it.bank = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
				: 4'($urandom_range(0, 8));
			case ($urandom_range(0, 3))
				0: it.control = 8'($urandom);
				1: it.control = 8'(8'h80 | $urandom_range(0, 31));
				2: it.control = 8'h00;
				default: it.control = {1'b1, 2'b0, 5'($urandom)} ^ {2'b0, 6'($urandom) & 6'h20};
			endcase
		end else begin
			it.operation = OpLookup;
			it.region = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(12, 15))
				: 4'($urandom_range(0, 11));
			it.slot = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 40));
		end
		if ($urandom_range(0, 15) == 0) begin
			// fill the fields the operation does not use
			if (it.operation == OpWrite) begin
				it.region = 4'($urandom); it.slot = 6'($urandom);
			end else begin
				it.bank = 4'($urandom); it.control = 8'($urandom);
			end
		end
		return it;
	endfunction

	initial begin
		row_t rows [$];
		int   gap;
		errors = 0; long_hold = 0;
		in_valid = 0; in_item = '0; arst_n = 0;
		for (int i = 0; i < NumBanks; i++) begin p_ctl[i] = 0; p_en[i] = 0; end
		foreach (p_abg[i]) p_abg[i] = 0;
		foreach (p_aobj[i]) p_aobj[i] = 0;
		foreach (p_bbg[i]) p_bbg[i] = 0;
		foreach (p_tex[i]) p_tex[i] = 0;
		foreach (p_texpl[i]) p_texpl[i] = 0;
		p_arm7[0] = 0; p_arm7[1] = 0; p_abgpl[0] = 0; p_abgpl[1] = 0;
		p_bobj = 0; p_aobjpl = 0; p_small = 0; p_arm7b = 0;

		rows.push_back('{rd(RegLcdc, 0), 1, mk_res(0, 0, 0, 0, 0, 0, 0)});
		rows.push_back('{wr(0, 8'h80), 1, mk_res(0, 0, 0, 0, 0, 0, 0)});
		rows.push_back('{rd(RegLcdc, 5), 1, mk_res(0, 1, 0, 0, 5, 9'h001, 0)});
		rows.push_back('{wr(2, 8'h8A), 1, mk_res(0, 0, 0, 0, 0, 0, 2'b01)});
		rows.push_back('{rd(RegArm7, 1), 1, mk_res(0, 1, 0, 2, 0, 9'h004, 2'b01)});
		rows.push_back('{wr(3, 8'h87), 1, mk_res(1, 0, 0, 0, 0, 0, 2'b01)});
		rows.push_back('{wr(3, 8'h87), 1, mk_res(0, 0, 0, 0, 0, 0, 2'b01)});
		rows.push_back('{wr(9, 8'h81), 1, mk_res(0, 0, 0, 0, 0, 0, 2'b01)});
		rows.push_back('{wr(15, 8'hFF), 1, mk_res(0, 0, 0, 0, 0, 0, 2'b01)});
		rows.push_back('{wr(4, 8'h81), 0, '0});
		rows.push_back('{wr(0, 8'h81), 0, '0});
		rows.push_back('{rd(RegAbg, 3), 0, '0});
		rows.push_back('{rd(RegAbg, 31), 0, '0});
		rows.push_back('{wr(5, 8'h9A), 0, '0});
		rows.push_back('{wr(6, 8'h85), 0, '0});
		rows.push_back('{rd(RegAobPl, 0), 0, '0});
		rows.push_back('{wr(7, 8'h82), 0, '0});
		rows.push_back('{wr(8, 8'hFB), 0, '0});
		rows.push_back('{rd(RegBbgPl, 0), 0, '0});
		rows.push_back('{rd(RegBobPl, 0), 0, '0});
		rows.push_back('{wr(1, 8'h9B), 0, '0});
		rows.push_back('{rd(RegTex, 3), 0, '0});
		rows.push_back('{rd(RegLcdc, 63), 1, mk_res(0, 0, 0, 0, 0, 0, 2'b01)});
		rows.push_back('{rd(4'd15, 0), 1, mk_res(0, 0, 0, 0, 0, 0, 2'b01)});
		rows.push_back('{wr(2, 8'h00), 1, mk_res(0, 0, 0, 0, 0, 0, 2'b00)});

		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (rows[i])
			send(rows[i].item, rows[i].typed, rows[i].res, (i % 5 == 0) ? 0 : $urandom_range(0, 2));

		for (int n = 0; n < 1300; n++) begin
			if (n == 400) long_hold = 1;
			if (n == 800) begin
				in_valid <= 0;
				while (expected_results.size() != 0) @(posedge clk);
			end
			if ((n / 100) % 3 == 2 || long_hold) gap = 0;
			else gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
			send(rand_item(), 0, '0, gap);
		end
		in_valid <= 0;

		while (expected_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
`default_nettype wire

// ===== video_memory_bank_mapper_unit.f =====
src/vmbm_pkg.sv
src/vmbm_update.sv
src/vmbm_lookup.sv
src/video_memory_bank_mapper_unit.sv
src/vmbm_checker.sv
tb/testbench.sv
